// ===== design/sdr_pkg.sv =====
// Package with types and constants for the symmetry diagonal relaxation block.
package sdr_pkg;

  localparam int Dim = 3;
  localparam int DataW = 32;
  localparam int CfgW = 17;
  localparam logic [CfgW-1:0] RelaxOne = 17'h10000;

  localparam int DenW = 64;
  localparam int NumW = 96;
  localparam int QBits = 34;
  localparam int RemW = DenW + QBits;
  localparam int MagW = QBits + 1;
  localparam int LatDiv = QBits + 1;
  localparam int PipeLat = LatDiv + 8;

  typedef struct packed {
    logic signed [31:0] block_00;
    logic signed [31:0] block_01;
    logic signed [31:0] block_02;
    logic signed [31:0] block_10;
    logic signed [31:0] block_11;
    logic signed [31:0] block_12;
    logic signed [31:0] block_20;
    logic signed [31:0] block_21;
    logic signed [31:0] block_22;
    logic signed [31:0] area_x;
    logic signed [31:0] area_y;
    logic signed [31:0] area_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_00;
    logic signed [31:0] new_01;
    logic signed [31:0] new_02;
    logic signed [31:0] new_10;
    logic signed [31:0] new_11;
    logic signed [31:0] new_12;
    logic signed [31:0] new_20;
    logic signed [31:0] new_21;
    logic signed [31:0] new_22;
    logic               zero_area;
    logic               saturated;
  } out_t;

  // Data that rides alongside the divider lanes.
  typedef struct packed {
    logic [8:0][31:0] d;
    logic [8:0]       mneg;
    logic             zero;
    logic [CfgW-1:0]  f;
  } side_t;

endpackage

// ===== design/symmetry_diagonal_relaxation_top.sv =====
// Top level of the symmetry diagonal relaxation pipeline.
//
// Channel   Direction  Handshake                      Payload
// command   in         start_i, busy_o                item_i (sdr_pkg::in_t)
// result    out        result_valid_o (strobe)        result_o (sdr_pkg::out_t)
// config    in         cfg_we_i                       cfg_wdata_i (relax_factor)
//
// One transaction enters per cycle; busy_o stays low.
// The pipeline depth is dominated by the 34 one-bit steps of the divider.
// Reset clears all valid bits and loads relax_factor with 1.0.
// The receiver cannot stall, so the pipeline advances every cycle.
module symmetry_diagonal_relaxation_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  sdr_pkg::in_t                item_i,
  output logic                        result_valid_o,
  output sdr_pkg::out_t               result_o,
  input  logic                        cfg_we_i,
  input  logic [sdr_pkg::CfgW-1:0]    cfg_wdata_i
);

  logic [sdr_pkg::CfgW-1:0] relax_q;
  logic [sdr_pkg::CfgW-1:0] f_d;

  logic signed [31:0] din [9];
  logic signed [31:0] ain [3];

  logic                     v1_q, v2_q, v3_q, v4_q, v5_q, vp_q, vr_q, vo_q;
  logic signed [31:0]       d1_q [9], d2_q [9], d3_q [9];
  logic signed [31:0]       a1_q [3], a2_q [3];
  logic [sdr_pkg::CfgW-1:0] f1_q, f2_q, f3_q;
  logic signed [63:0]       p1_q [3][3];
  logic signed [63:0]       sq1_q [3];
  logic [63:0]              s2_q, s3_q, s4_q, s5_q;
  logic signed [65:0]       vs2_q [3];
  logic [63:0]              vmag3_q [3];
  logic                     vneg3_q [3];
  logic [31:0]              am3_q [3];
  logic                     aneg3_q [3];
  logic                     zero3_q;
  logic [63:0]              lo4_q [9], hi4_q [9];
  sdr_pkg::side_t           side4_q, side5_q, sidep_q, sider_q;
  logic [sdr_pkg::NumW-1:0] num5_q [9];
  logic [sdr_pkg::MagW-1:0] quo [9];
  sdr_pkg::side_t           sdel_q [sdr_pkg::LatDiv];
  logic                     vdel_q [sdr_pkg::LatDiv];
  logic [51:0]              prod_q [9];
  logic signed [36:0]       delta_q [9];
  logic signed [31:0]       res_d [9];
  logic                     sat_d;
  sdr_pkg::out_t            result_q;
  logic                     accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign din = '{item_i.block_00, item_i.block_01, item_i.block_02,
                 item_i.block_10, item_i.block_11, item_i.block_12,
                 item_i.block_20, item_i.block_21, item_i.block_22};
  assign ain = '{item_i.area_x, item_i.area_y, item_i.area_z};

  assign f_d = sdr_pkg::RelaxOne -
               ((relax_q > sdr_pkg::RelaxOne) ? sdr_pkg::RelaxOne : relax_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= sdr_pkg::RelaxOne;
    end else if (cfg_we_i) begin
      relax_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vdel_q <= '{default: 1'b0};
      vp_q <= 1'b0;
      vr_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vdel_q[0] <= v5_q;
      for (int t = 1; t < sdr_pkg::LatDiv; t++) vdel_q[t] <= vdel_q[t-1];
      vp_q <= vdel_q[sdr_pkg::LatDiv-1];
      vr_q <= vp_q;
      vo_q <= vr_q;
    end
  end

  // Stage 1: entry products and squares of the area components.
  always_ff @(posedge clk_i) begin
    d1_q <= din;
    a1_q <= ain;
    f1_q <= f_d;
    for (int k = 0; k < 3; k++) begin
      sq1_q[k] <= (k < sdr_pkg::Dim) ? ain[k] * ain[k] : 64'sd0;
      for (int i = 0; i < 3; i++) begin
        p1_q[i][k] <= (k < sdr_pkg::Dim) ? din[3*i+k] * ain[k] : 64'sd0;
      end
    end
  end

  // Stage 2: squared length and row sums.
  always_ff @(posedge clk_i) begin
    d2_q <= d1_q;
    a2_q <= a1_q;
    f2_q <= f1_q;
    s2_q <= 64'(sq1_q[0]) + 64'(sq1_q[1]) + 64'(sq1_q[2]);
    for (int i = 0; i < 3; i++) begin
      vs2_q[i] <= 66'(p1_q[i][0]) + 66'(p1_q[i][1]) + 66'(p1_q[i][2]);
    end
  end

  // Stage 3: sign and magnitude split.
  always_ff @(posedge clk_i) begin
    d3_q <= d2_q;
    f3_q <= f2_q;
    s3_q <= s2_q;
    zero3_q <= (s2_q == 64'd0);
    for (int i = 0; i < 3; i++) begin
      vneg3_q[i] <= vs2_q[i][65];
      vmag3_q[i] <= vs2_q[i][65] ? 64'(-vs2_q[i]) : 64'(vs2_q[i]);
      aneg3_q[i] <= a2_q[i][31];
      am3_q[i] <= a2_q[i][31] ? 32'(-a2_q[i]) : 32'(a2_q[i]);
    end
  end

  // Stage 4: the 64x32 numerator product as two 32x32 partial products.
  always_ff @(posedge clk_i) begin
    s4_q <= s3_q;
    side4_q.zero <= zero3_q;
    side4_q.f <= f3_q;
    for (int e = 0; e < 9; e++) begin
      side4_q.d[e] <= d3_q[e];
      side4_q.mneg[e] <= vneg3_q[e/3] ^ aneg3_q[e%3];
      lo4_q[e] <= vmag3_q[e/3][31:0] * am3_q[e%3];
      hi4_q[e] <= vmag3_q[e/3][63:32] * am3_q[e%3];
    end
  end

  // Stage 5: partial products combined into the dividend.
  always_ff @(posedge clk_i) begin
    s5_q <= s4_q;
    side5_q <= side4_q;
    for (int e = 0; e < 9; e++) begin
      num5_q[e] <= {hi4_q[e], 32'd0} + {32'd0, lo4_q[e]};
    end
  end

  for (genvar e = 0; e < 9; e++) begin : g_lane
    sdr_div u_div (
      .clk_i (clk_i),
      .num_i (num5_q[e]),
      .den_i (s5_q),
      .quo_o (quo[e])
    );
  end

  always_ff @(posedge clk_i) begin
    sdel_q[0] <= side5_q;
    for (int t = 1; t < sdr_pkg::LatDiv; t++) sdel_q[t] <= sdel_q[t-1];
  end

  // Scale by (1 - urf), round, then add and clamp.
  always_ff @(posedge clk_i) begin
    sidep_q <= sdel_q[sdr_pkg::LatDiv-1];
    for (int e = 0; e < 9; e++) begin
      prod_q[e] <= sdel_q[sdr_pkg::LatDiv-1].f * quo[e];
    end
  end

  always_ff @(posedge clk_i) begin
    sider_q <= sidep_q;
    for (int e = 0; e < 9; e++) begin
      delta_q[e] <= sidep_q.mneg[e] ?
                    -$signed({1'b0, 36'((prod_q[e] + 52'd32768) >> 16)}) :
                     $signed({1'b0, 36'((prod_q[e] + 52'd32768) >> 16)});
    end
  end

  always_comb begin
    logic signed [37:0] n;
    logic signed [31:0] dv;
    sat_d = 1'b0;
    for (int e = 0; e < 9; e++) begin
      dv = sider_q.d[e];
      n = {{6{dv[31]}}, dv} + {delta_q[e][36], delta_q[e]};
      if (sider_q.zero || (e / 3) >= sdr_pkg::Dim || (e % 3) >= sdr_pkg::Dim) begin
        res_d[e] = dv;
      end else if (n > 38'sd2147483647) begin
        res_d[e] = 32'sh7fffffff;
        sat_d = 1'b1;
      end else if (n < -38'sd2147483648) begin
        res_d[e] = 32'sh80000000;
        sat_d = 1'b1;
      end else begin
        res_d[e] = n[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.new_00 <= res_d[0];
    result_q.new_01 <= res_d[1];
    result_q.new_02 <= res_d[2];
    result_q.new_10 <= res_d[3];
    result_q.new_11 <= res_d[4];
    result_q.new_12 <= res_d[5];
    result_q.new_20 <= res_d[6];
    result_q.new_21 <= res_d[7];
    result_q.new_22 <= res_d[8];
    result_q.zero_area <= sider_q.zero;
    result_q.saturated <= sat_d;
  end

  assign result_valid_o = vo_q;
  assign result_o = result_q;

  // Every accepted transaction comes out after the fixed pipeline latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(sdr_pkg::PipeLat) result_valid_o)
    else $error("accepted transaction did not produce a result in time");

  // A zero area vector never reports saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.zero_area |-> !result_o.saturated)
    else $error("zero area result flagged as saturated");

  // A zero area vector passes the leading entry through unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.zero_area |->
      result_o.new_00 == $past(item_i.block_00, sdr_pkg::PipeLat))
    else $error("zero area result altered the block");

endmodule

// ===== design/sdr_div.sv =====
// Pipelined restoring divider with round-to-nearest on the final remainder.
module sdr_div (
  input  logic                         clk_i,
  input  logic [sdr_pkg::NumW-1:0]     num_i,
  input  logic [sdr_pkg::DenW-1:0]     den_i,
  output logic [sdr_pkg::MagW-1:0]     quo_o
);

  logic [sdr_pkg::RemW-1:0]  rem_q [sdr_pkg::QBits];
  logic [sdr_pkg::QBits-1:0] quo_q [sdr_pkg::QBits];
  logic [sdr_pkg::DenW-1:0]  den_q [sdr_pkg::QBits];
  logic                      rnd;

  for (genvar t = 0; t < sdr_pkg::QBits; t++) begin : g_step
    localparam int B = sdr_pkg::QBits - 1 - t;
    logic [sdr_pkg::RemW-1:0]  rem_in;
    logic [sdr_pkg::QBits-1:0] quo_in;
    logic [sdr_pkg::DenW-1:0]  den_in;
    logic [sdr_pkg::RemW-1:0]  shifted;
    logic                      ge;
    if (t == 0) begin : g_first
      assign rem_in = sdr_pkg::RemW'(num_i);
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_rest
      assign rem_in = rem_q[t-1];
      assign quo_in = quo_q[t-1];
      assign den_in = den_q[t-1];
    end
    assign shifted = {{sdr_pkg::QBits{1'b0}}, den_in} << B;
    assign ge = rem_in >= shifted;
    always_ff @(posedge clk_i) begin
      rem_q[t] <= ge ? rem_in - shifted : rem_in;
      quo_q[t] <= ge ? quo_in | (sdr_pkg::QBits'(1) << B) : quo_in;
      den_q[t] <= den_in;
    end
  end

  // The final remainder is below the divisor, so its low bits suffice.
  assign rnd = {rem_q[sdr_pkg::QBits-1][sdr_pkg::DenW-1:0], 1'b0} >=
               {1'b0, den_q[sdr_pkg::QBits-1]};

  always_ff @(posedge clk_i) begin
    quo_o <= sdr_pkg::MagW'(quo_q[sdr_pkg::QBits-1]) + sdr_pkg::MagW'(rnd);
  end

endmodule
